>>> design/gwws_pkg.sv
package gwws_pkg;

  localparam int MAX_WIDTH = 48;
  localparam int IDX_W     = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 6;

  localparam logic [CHAR_W-1:0] SPACE_BYTE   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [CFG_W-1:0]  WIDTH_RESET  = 6'd32;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } emit_t;

  // (base + offset) modulo MAX_WIDTH; both operands stay below MAX_WIDTH + 1
  function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
                                                 logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(base) + (IDX_W+1)'(offset);
    if (sum >= (IDX_W+1)'(MAX_WIDTH)) begin
      sum = sum - (IDX_W+1)'(MAX_WIDTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

>>> design/gwws_ram.sv
module gwws_ram #(
  parameter int DEPTH  = 48,
  parameter int DATA_W = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/gwws_ctrl.sv
module gwws_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gwws_pkg::CHAR_W-1:0]   in_char,
  input  logic                          end_of_text,
  input  logic [gwws_pkg::CFG_W-1:0]    line_width,
  output gwws_pkg::mem_req_t            mem_req,
  input  logic [gwws_pkg::CHAR_W-1:0]   mem_rdata,
  input  logic                          out_free,
  output gwws_pkg::emit_t               emit
);

  localparam int IDX_W  = gwws_pkg::IDX_W;
  localparam int ADDR_W = gwws_pkg::ADDR_W;
  localparam int CFG_W  = gwws_pkg::CFG_W;
  localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(gwws_pkg::MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_NEWLINE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] head;      // physical slot of logical index 0
  logic [IDX_W-1:0]  len;
  logic              sp_seen;
  logic [IDX_W-1:0]  sp;
  logic              eot;
  logic              flush;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  run_len;

  logic [IDX_W-1:0]  w_eff;
  logic [IDX_W-1:0]  rest;
  logic [IDX_W-1:0]  cnt_next;
  logic              run_done;

  always_comb begin
    if (line_width == '0) begin
      w_eff = IDX_W'(1);
    end else if ((CFG_W+1)'(line_width) > (CFG_W+1)'(gwws_pkg::MAX_WIDTH)) begin
      w_eff = MAX_LEN;
    end else begin
      w_eff = IDX_W'(line_width);
    end
  end

  assign rest     = sp_seen ? (len - sp - IDX_W'(1)) : '0;
  assign cnt_next = cnt + IDX_W'(1);
  assign run_done = (cnt_next == run_len);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    mem_req.we    = in_valid && (state == S_IDLE) && (len < MAX_LEN);
    mem_req.waddr = gwws_pkg::wrap_add(head, len);
    mem_req.wdata = in_char;
    mem_req.re    = (state == S_READ);
    mem_req.raddr = gwws_pkg::wrap_add(head, cnt);
  end

  always_comb begin
    emit.valid = 1'b0;
    emit.ch    = gwws_pkg::NEWLINE_BYTE;
    emit.last  = 1'b0;
    if (state == S_LOAD) begin
      emit.valid = out_free;
      emit.ch    = mem_rdata;
      emit.last  = flush && run_done;
    end else if (state == S_NEWLINE) begin
      emit.valid = out_free;
      emit.last  = eot && (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      len     <= '0;
      sp_seen <= 1'b0;
      sp      <= '0;
      eot     <= 1'b0;
      flush   <= 1'b0;
      cnt     <= '0;
      run_len <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (len < MAX_LEN) begin
              len <= len + IDX_W'(1);
              if (in_char == gwws_pkg::SPACE_BYTE) begin
                sp_seen <= 1'b1;
                sp      <= len;
              end
            end
            eot   <= end_of_text;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt <= '0;
          if (len >= w_eff) begin
            // break: up to the held space, or the whole line
            flush   <= 1'b0;
            run_len <= sp_seen ? sp : len;
            if ((sp_seen && sp == '0) || len == '0) begin
              state <= S_NEWLINE;
            end else begin
              state <= S_READ;
            end
          end else if (eot && len != '0) begin
            flush   <= 1'b1;
            run_len <= len;
            state   <= S_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            cnt <= cnt_next;
            if (run_done) begin
              if (flush) begin
                len     <= '0;
                sp_seen <= 1'b0;
                sp      <= '0;
                state   <= S_IDLE;
              end else begin
                state <= S_NEWLINE;
              end
            end else begin
              state <= S_READ;
            end
          end
        end
        S_NEWLINE: begin
          if (out_free) begin
            // the space itself is dropped; the tail after it stays pending
            if (sp_seen) begin
              head <= gwws_pkg::wrap_add(head, sp + IDX_W'(1));
            end
            len     <= rest;
            sp_seen <= 1'b0;
            sp      <= '0;
            if (eot && rest != '0) begin
              flush   <= 1'b1;
              run_len <= rest;
              cnt     <= '0;
              state   <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/greedy_word_wrap_stream.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_char, end_of_text
// output    out_valid / out_ready   out_char, last
// config    cfg_we                  cfg_wdata (line_width)
//
// One item at a time: each input byte is accepted, then line-checked; each
// emitted text byte then takes a line memory read and an output register load,
// and an inserted newline an output register load only, plus any output stall.
// The pending line lives in a 48-entry circular memory; a break moves the
// head pointer past the space instead of shifting bytes.
// Reset is synchronous; it clears the line state and sets line_width to 32.
// No clearing pass: only written entries are ever read.
module greedy_word_wrap_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gwws_pkg::CHAR_W-1:0] in_char,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gwws_pkg::CHAR_W-1:0] out_char,
  output logic                        last,
  input  logic                        cfg_we,
  input  logic [gwws_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [gwws_pkg::CFG_W-1:0]  line_width;
  gwws_pkg::mem_req_t          mem_req;
  logic [gwws_pkg::CHAR_W-1:0] mem_rdata;
  gwws_pkg::emit_t             emit;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= gwws_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  assign out_free = !out_valid || out_ready;

  gwws_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .line_width  (line_width),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .out_free    (out_free),
    .emit        (emit)
  );

  gwws_ram #(
    .DEPTH  (gwws_pkg::MAX_WIDTH),
    .DATA_W (gwws_pkg::CHAR_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_char <= emit.ch;
      last     <= emit.last;
    end
  end

endmodule

>>> design/gwws_checker.sv
module gwws_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
    else $error("output item changed while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // an idle controller emits nothing, so a taken output item leaves the port empty
  a_idle_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && in_ready |=> !out_valid)
    else $error("output item appeared while idle");

  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind greedy_word_wrap_stream gwws_checker u_gwws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .last      (last)
);
